FILE: rtl/hcm_pkg.sv
// Shared types, constants and mod-26 helpers for the 3x3 Hill cipher block.
package hcm_pkg;

    localparam int ALPHA         = 26;
    localparam int LW            = 5;
    localparam int AW            = 11;
    localparam int KEY_W         = 45;
    localparam int N             = 3;
    localparam int CFG_IW        = 4;
    localparam int DERIVE_CYCLES = 7;
    localparam int CNT_W         = $clog2(DERIVE_CYCLES + 1);
    localparam int RECIP         = 2521;
    localparam int RECIP_SH      = 16;
    localparam int PW            = AW + 12;
    localparam int ADJ_BIAS      = (ALPHA - 1) * ALPHA;

    typedef logic [LW-1:0] t_letter;
    typedef logic [AW-1:0] t_acc;
    typedef t_letter [N*N-1:0] t_mat;
    typedef t_letter [N-1:0] t_vec;

    typedef enum logic [CFG_IW-1:0] {
        CFG_KEY_MATRIX   = 4'd0,
        CFG_DECRYPT_MODE = 4'd1
    } t_cfg_reg;

    typedef struct packed {
        t_mat m;
        logic err;
        logic busy;
    } t_key_status;

    function automatic t_letter mod26_small(input t_letter x);
        mod26_small = (x >= t_letter'(ALPHA)) ? t_letter'(x - t_letter'(ALPHA)) : x;
    endfunction

    // x mod 26 for x below 2048 by reciprocal multiply, one correction
    function automatic t_letter mod26(input t_acc x);
        logic [PW-1:0] p;
        logic [PW-1:0] q;
        t_acc          r;
        p = PW'(x) * PW'(RECIP);
        q = p >> RECIP_SH;
        r = t_acc'(x - t_acc'(q[AW-1:0] * t_acc'(ALPHA)));
        if (r >= t_acc'(ALPHA)) begin
            r = t_acc'(r - t_acc'(ALPHA));
        end
        mod26 = r[LW-1:0];
    endfunction

    // inverse mod 26, zero where none exists
    function automatic t_letter inv26(input t_letter d);
        case (d)
            5'd1:    inv26 = 5'd1;
            5'd3:    inv26 = 5'd9;
            5'd5:    inv26 = 5'd21;
            5'd7:    inv26 = 5'd15;
            5'd9:    inv26 = 5'd3;
            5'd11:   inv26 = 5'd19;
            5'd15:   inv26 = 5'd7;
            5'd17:   inv26 = 5'd23;
            5'd19:   inv26 = 5'd11;
            5'd21:   inv26 = 5'd5;
            5'd23:   inv26 = 5'd17;
            5'd25:   inv26 = 5'd25;
            default: inv26 = 5'd0;
        endcase
    endfunction

endpackage

FILE: rtl/hcm_keyinv.sv
// Configuration registers and pipelined derivation of the working matrix.
module hcm_keyinv (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [hcm_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [hcm_pkg::KEY_W-1:0]  i_cfg_data,
    output hcm_pkg::t_key_status       o_status
);
    import hcm_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic             r_mode;
    logic [CNT_W-1:0] r_cnt;

    t_mat                 r_k;
    t_acc [N*N-1:0]       r_adjraw;
    t_mat                 r_adj;
    t_acc                 r_detraw;
    t_letter              r_dinv;
    logic [N*N-1:0] [2*LW-1:0] r_prod;
    logic                 r_err6;
    t_mat                 r_m;
    logic                 r_err;

    // p*q - r*s made non-negative by a multiple of 26
    function automatic t_acc diff(input t_letter p, input t_letter q,
                                  input t_letter r, input t_letter s);
        diff = t_acc'(t_acc'(p) * t_acc'(q) + t_acc'(ADJ_BIAS) - t_acc'(r) * t_acc'(s));
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_mode <= 1'b0;
            r_cnt  <= CNT_W'(DERIVE_CYCLES);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KEY_MATRIX:   r_key  <= i_cfg_data;
                    CFG_DECRYPT_MODE: r_mode <= i_cfg_data[0];
                    default:          ;
                endcase
                r_cnt <= CNT_W'(DERIVE_CYCLES);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < N*N; e++) begin
            r_k[e] <= mod26_small(r_key[e*LW +: LW]);
        end
        r_adjraw[0] <= diff(r_k[4], r_k[8], r_k[5], r_k[7]);
        r_adjraw[1] <= diff(r_k[2], r_k[7], r_k[1], r_k[8]);
        r_adjraw[2] <= diff(r_k[1], r_k[5], r_k[2], r_k[4]);
        r_adjraw[3] <= diff(r_k[5], r_k[6], r_k[3], r_k[8]);
        r_adjraw[4] <= diff(r_k[0], r_k[8], r_k[2], r_k[6]);
        r_adjraw[5] <= diff(r_k[2], r_k[3], r_k[0], r_k[5]);
        r_adjraw[6] <= diff(r_k[3], r_k[7], r_k[4], r_k[6]);
        r_adjraw[7] <= diff(r_k[1], r_k[6], r_k[0], r_k[7]);
        r_adjraw[8] <= diff(r_k[0], r_k[4], r_k[1], r_k[3]);
        for (int e = 0; e < N*N; e++) begin
            r_adj[e]  <= mod26(r_adjraw[e]);
            r_prod[e] <= (2*LW)'(r_adj[e]) * (2*LW)'(r_dinv);
            r_m[e]    <= r_mode ? mod26(AW'(r_prod[e])) : r_k[e];
        end
        r_detraw <= t_acc'(t_acc'(r_k[0]) * t_acc'(r_adj[0])
                         + t_acc'(r_k[1]) * t_acc'(r_adj[3])
                         + t_acc'(r_k[2]) * t_acc'(r_adj[6]));
        r_dinv   <= inv26(mod26(r_detraw));
        r_err6   <= (r_dinv == '0);
        r_err    <= r_mode & r_err6;
    end

    assign o_status.m    = r_m;
    assign o_status.err  = r_err;
    assign o_status.busy = (r_cnt != '0);

endmodule

FILE: rtl/hcm_lane.sv
// One lane: dot product of a matrix row with the letter block.
module hcm_lane (
    input  hcm_pkg::t_vec i_row,
    input  hcm_pkg::t_vec i_vec,
    output hcm_pkg::t_acc o_acc
);
    import hcm_pkg::*;

    assign o_acc = t_acc'(t_acc'(i_row[0]) * t_acc'(i_vec[0])
                        + t_acc'(i_row[1]) * t_acc'(i_vec[1])
                        + t_acc'(i_row[2]) * t_acc'(i_vec[2]));

endmodule

FILE: rtl/hcm_merge.sv
// Merge stage: reduce lane sums mod 26 and apply the singular-key flag.
module hcm_merge (
    input  hcm_pkg::t_acc [hcm_pkg::N-1:0] i_acc,
    input  logic                           i_err,
    output hcm_pkg::t_vec                  o_letters,
    output logic                           o_err
);
    import hcm_pkg::*;

    always_comb begin
        for (int l = 0; l < N; l++) begin
            o_letters[l] = i_err ? '0 : mod26(i_acc[l]);
        end
    end

    assign o_err = i_err;

endmodule

FILE: rtl/hill_cipher_3x3_mod26.sv
// Top level of the 3x3 mod-26 Hill cipher engine.
//
// Input channel: i_valid / o_stall carry a block of three letters; a transfer
// happens on a rising edge with i_valid high and o_stall low. Output channel:
// o_valid / i_stall carry three result letters and the singular-key flag.
// Config channel: i_cfg_valid / o_cfg_ready, index 0 key matrix, 1 decrypt
// mode; o_cfg_ready is always high, other indexes are ignored.
// One block per cycle is sustained while o_stall is low, through the three lane
// pipeline (reduce, dot product, merge).
// After reset and after every config write the working matrix is rebuilt by
// a 7-stage derivation pipeline (adjugate, determinant, inverse, scaling);
// o_stall stays high while it runs. Reset clears the key to zero, selects
// encrypt and empties the pipeline.
// When the receiver stalls while o_valid is high the whole pipeline holds and
// o_stall rises, so a finished result waits in the output register while the
// stages behind it keep their blocks.
module hill_cipher_3x3_mod26 (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [hcm_pkg::LW-1:0]     i_letter_in_0,
    input  logic [hcm_pkg::LW-1:0]     i_letter_in_1,
    input  logic [hcm_pkg::LW-1:0]     i_letter_in_2,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [hcm_pkg::LW-1:0]     o_letter_out_0,
    output logic [hcm_pkg::LW-1:0]     o_letter_out_1,
    output logic [hcm_pkg::LW-1:0]     o_letter_out_2,
    output logic                       o_key_not_invertible,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [hcm_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [hcm_pkg::KEY_W-1:0]  i_cfg_data
);
    import hcm_pkg::*;

    t_key_status    ks;
    logic           en;
    logic           accept;
    logic           r_v1;
    logic           r_v2;
    logic           r_v3;
    t_vec           r_s1;
    t_acc [N-1:0]   r_acc;
    t_acc [N-1:0]   n_acc;
    t_vec           r_out;
    t_vec           n_out;
    logic           r_err;
    logic           n_err;

    assign o_cfg_ready = 1'b1;

    hcm_keyinv u_keyinv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_status    (ks)
    );

    assign en      = !r_v3 || !i_stall;
    assign o_stall = !en || ks.busy;
    assign accept  = i_valid && !o_stall;

    for (genvar l = 0; l < N; l++) begin : g_lane
        hcm_lane u_lane (
            .i_row (ks.m[l*N +: N]),
            .i_vec (r_s1),
            .o_acc (n_acc[l])
        );
    end

    hcm_merge u_merge (
        .i_acc     (r_acc),
        .i_err     (ks.err),
        .o_letters (n_out),
        .o_err     (n_err)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1[0] <= mod26_small(i_letter_in_0);
            r_s1[1] <= mod26_small(i_letter_in_1);
            r_s1[2] <= mod26_small(i_letter_in_2);
            r_acc   <= n_acc;
            r_out   <= n_out;
            r_err   <= n_err;
        end
    end

    assign o_valid              = r_v3;
    assign o_letter_out_0       = r_out[0];
    assign o_letter_out_1       = r_out[1];
    assign o_letter_out_2       = r_out[2];
    assign o_key_not_invertible = r_err;

    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> o_stall)
        else $error("input not held off after config write");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_key_not_invertible) |->
        (o_letter_out_0 == '0 && o_letter_out_1 == '0 && o_letter_out_2 == '0))
        else $error("letters not cleared on singular key");

    a_letter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_letter_out_0 < LW'(ALPHA) && o_letter_out_1 < LW'(ALPHA)
                     && o_letter_out_2 < LW'(ALPHA)))
        else $error("result letter out of range");

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the 3x3 mod-26 Hill cipher: directed table, then random.
`timescale 1ns / 1ps

module tb;
    import hcm_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 20;
    localparam int PHASE_BLOCKS  = 20;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        t_letter [2:0] letter;
        logic          bad;
    } t_hill_block;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             decrypt;
        t_letter [2:0]    text;
        logic             typed;
        t_hill_block      want;
    } t_block_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    t_letter           i_letter_in_0 = '0;
    t_letter           i_letter_in_1 = '0;
    t_letter           i_letter_in_2 = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    t_letter           o_letter_out_0;
    t_letter           o_letter_out_1;
    t_letter           o_letter_out_2;
    logic              o_key_not_invertible;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [KEY_W-1:0]  i_cfg_data = '0;

    t_hill_block      pending_blocks[$];
    logic [KEY_W-1:0] shadow_key = '0;
    logic             shadow_decrypt = 1'b0;
    logic             calm = 1'b1;
    int               stall_left = 0;
    int               cycles = 0;
    int               mismatches = 0;
    int               blocks_sent = 0;
    int               settings_used = 1;
    int               singular_seen = 0;

    hill_cipher_3x3_mod26 dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_letter_in_0        (i_letter_in_0),
        .i_letter_in_1        (i_letter_in_1),
        .i_letter_in_2        (i_letter_in_2),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_letter_out_0       (o_letter_out_0),
        .o_letter_out_1       (o_letter_out_1),
        .o_letter_out_2       (o_letter_out_2),
        .o_key_not_invertible (o_key_not_invertible),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results outstanding",
                     cycles, pending_blocks.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int wrap26(input int v);
        int r;
        r = v % ALPHA;
        if (r < 0) r += ALPHA;
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] pack_key(input int e0, input int e1, input int e2,
                                                  input int e3, input int e4, input int e5,
                                                  input int e6, input int e7, input int e8);
        return {t_letter'(e8), t_letter'(e7), t_letter'(e6), t_letter'(e5), t_letter'(e4),
                t_letter'(e3), t_letter'(e2), t_letter'(e1), t_letter'(e0)};
    endfunction

    // key (or its mod-26 inverse) times the block
    function automatic t_hill_block hill_transform(input logic [KEY_W-1:0] key,
                                                   input logic decrypt,
                                                   input t_letter [2:0] text);
        int k[3][3];
        int adj[3][3];
        int w[3][3];
        int x[3];
        int det;
        int dinv;
        int acc;
        t_hill_block r;
        r = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                k[i][j] = wrap26(int'(key[LW*(3*i+j) +: LW]));
            end
            x[i] = wrap26(int'(text[i]));
        end
        if (!decrypt) begin
            w = k;
        end else begin
            adj[0][0] = k[1][1] * k[2][2] - k[1][2] * k[2][1];
            adj[0][1] = -(k[0][1] * k[2][2] - k[0][2] * k[2][1]);
            adj[0][2] = k[0][1] * k[1][2] - k[0][2] * k[1][1];
            adj[1][0] = -(k[1][0] * k[2][2] - k[1][2] * k[2][0]);
            adj[1][1] = k[0][0] * k[2][2] - k[0][2] * k[2][0];
            adj[1][2] = -(k[0][0] * k[1][2] - k[0][2] * k[1][0]);
            adj[2][0] = k[1][0] * k[2][1] - k[1][1] * k[2][0];
            adj[2][1] = -(k[0][0] * k[2][1] - k[0][1] * k[2][0]);
            adj[2][2] = k[0][0] * k[1][1] - k[0][1] * k[1][0];
            det = wrap26(k[0][0] * adj[0][0] + k[0][1] * adj[1][0] + k[0][2] * adj[2][0]);
            dinv = -1;
            for (int t = 1; t < ALPHA; t++) begin
                if (dinv < 0 && (det * t) % ALPHA == 1) dinv = t;
            end
            if (dinv < 0) begin
                r.bad = 1'b1;
                return r;
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    w[i][j] = wrap26(wrap26(adj[i][j]) * dinv);
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            acc = w[i][0] * x[0] + w[i][1] * x[1] + w[i][2] * x[2];
            r.letter[i] = t_letter'(wrap26(acc));
        end
        return r;
    endfunction

    function automatic t_block_row dir_row(input logic [KEY_W-1:0] key, input logic decrypt,
                                           input int a, input int b, input int c,
                                           input logic typed, input int w0, input int w1,
                                           input int w2, input logic wbad);
        t_block_row r;
        r.key = key;
        r.decrypt = decrypt;
        r.text = {t_letter'(c), t_letter'(b), t_letter'(a)};
        r.typed = typed;
        r.want.letter = {t_letter'(w2), t_letter'(w1), t_letter'(w0)};
        r.want.bad = wbad;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at cycle %0d: %s got %0d, want %0d", cycles, what, got, want);
        mismatches++;
    endtask

    task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [KEY_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_KEY_MATRIX:   shadow_key = data;
            CFG_DECRYPT_MODE: shadow_decrypt = data[0];
            default: ;
        endcase
    endtask

    // drain, then load a new key/mode; sometimes pokes an unused index
    task automatic retune(input logic [KEY_W-1:0] key, input logic decrypt);
        logic [KEY_W-1:0] data;
        i_valid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (key != shadow_key) cfg_write(CFG_KEY_MATRIX, key);
        if ($urandom_range(0, 2) == 0) begin
            cfg_write(CFG_IW'($urandom_range(int'(CFG_DECRYPT_MODE) + 1, (1 << CFG_IW) - 1)),
                      KEY_W'({$urandom, $urandom}));
        end
        if (decrypt != shadow_decrypt) begin
            data = KEY_W'({$urandom, $urandom});
            data[0] = decrypt;
            cfg_write(CFG_DECRYPT_MODE, data);
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_block(input t_letter [2:0] text, input logic typed,
                              input t_hill_block fixed);
        t_hill_block want;
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_letter_in_0 <= text[0];
        i_letter_in_1 <= text[1];
        i_letter_in_2 <= text[2];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        want = typed ? fixed : hill_transform(shadow_key, shadow_decrypt, text);
        pending_blocks.push_back(want);
        blocks_sent++;
        if (want.bad) singular_seen++;
    endtask

    // receiver back-pressure in bursts of random length
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 18);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_hill_block want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_blocks.size() == 0) begin
                note_mismatch("unexpected result transfer", 1, 0);
            end else begin
                want = pending_blocks.pop_front();
                if (o_letter_out_0 !== want.letter[0])
                    note_mismatch("letter_out_0", o_letter_out_0, want.letter[0]);
                if (o_letter_out_1 !== want.letter[1])
                    note_mismatch("letter_out_1", o_letter_out_1, want.letter[1]);
                if (o_letter_out_2 !== want.letter[2])
                    note_mismatch("letter_out_2", o_letter_out_2, want.letter[2]);
                if (o_key_not_invertible !== want.bad)
                    note_mismatch("key_not_invertible", o_key_not_invertible, want.bad);
            end
        end
    end

    initial begin
        t_block_row       rows[$];
        logic [KEY_W-1:0] k_id;
        logic [KEY_W-1:0] k_ones;
        logic [KEY_W-1:0] k_hill;
        logic [KEY_W-1:0] key;
        logic             decrypt;
        t_letter [2:0]    text;

        k_id   = pack_key(1, 0, 0, 0, 1, 0, 0, 0, 1);
        k_ones = pack_key(1, 1, 1, 1, 1, 1, 1, 1, 1);
        k_hill = pack_key(6, 24, 1, 13, 16, 10, 20, 17, 15);

        // straight after reset: zero key, encrypt, then decrypt
        rows.push_back(dir_row('0, 1'b0, 25, 25, 25, 1'b1, 0, 0, 0, 1'b0));
        rows.push_back(dir_row('0, 1'b0, 31, 31, 31, 1'b1, 0, 0, 0, 1'b0));
        rows.push_back(dir_row('0, 1'b1, 5, 6, 7, 1'b1, 0, 0, 0, 1'b1));
        rows.push_back(dir_row(k_id, 1'b0, 0, 12, 25, 1'b1, 0, 12, 25, 1'b0));
        rows.push_back(dir_row(k_id, 1'b0, 26, 27, 31, 1'b1, 0, 1, 5, 1'b0));
        rows.push_back(dir_row(k_id, 1'b1, 31, 0, 26, 1'b1, 5, 0, 0, 1'b0));
        rows.push_back(dir_row(k_id, 1'b1, 3, 4, 5, 1'b1, 3, 4, 5, 1'b0));
        rows.push_back(dir_row(k_ones, 1'b1, 1, 2, 3, 1'b1, 0, 0, 0, 1'b1));
        rows.push_back(dir_row(k_ones, 1'b0, 1, 2, 3, 1'b1, 6, 6, 6, 1'b0));
        rows.push_back(dir_row(pack_key(13, 0, 0, 0, 1, 0, 0, 0, 1), 1'b0, 1, 1, 1,
                               1'b1, 13, 1, 1, 1'b0));
        rows.push_back(dir_row(pack_key(13, 0, 0, 0, 1, 0, 0, 0, 1), 1'b1, 1, 1, 1,
                               1'b1, 0, 0, 0, 1'b1));
        rows.push_back(dir_row(pack_key(2, 0, 0, 0, 1, 0, 0, 0, 1), 1'b1, 9, 9, 9,
                               1'b1, 0, 0, 0, 1'b1));
        // every entry 31, reduces to 5
        rows.push_back(dir_row('1, 1'b1, 2, 2, 2, 1'b1, 0, 0, 0, 1'b1));
        rows.push_back(dir_row('1, 1'b0, 1, 1, 1, 1'b1, 15, 15, 15, 1'b0));
        rows.push_back(dir_row(pack_key(25, 25, 25, 25, 25, 25, 25, 25, 25), 1'b0, 25, 25, 25,
                               1'b1, 3, 3, 3, 1'b0));
        rows.push_back(dir_row(pack_key(25, 25, 25, 25, 25, 25, 25, 25, 25), 1'b1, 0, 0, 0,
                               1'b1, 0, 0, 0, 1'b1));
        rows.push_back(dir_row(pack_key(27, 0, 0, 0, 27, 0, 0, 0, 27), 1'b1, 7, 8, 9,
                               1'b1, 7, 8, 9, 1'b0));
        rows.push_back(dir_row(pack_key(27, 0, 0, 0, 27, 0, 0, 0, 27), 1'b0, 7, 8, 9,
                               1'b1, 7, 8, 9, 1'b0));
        rows.push_back(dir_row(pack_key(25, 0, 0, 0, 25, 0, 0, 0, 25), 1'b1, 1, 0, 25,
                               1'b1, 25, 0, 1, 1'b0));
        rows.push_back(dir_row(k_hill, 1'b1, 15, 14, 7, 1'b1, 0, 2, 19, 1'b0));
        rows.push_back(dir_row(k_hill, 1'b1, 31, 30, 26, 1'b0, 0, 0, 0, 1'b0));
        rows.push_back(dir_row(k_hill, 1'b0, 0, 2, 19, 1'b1, 15, 14, 7, 1'b0));
        rows.push_back(dir_row(k_hill, 1'b0, 31, 30, 29, 1'b0, 0, 0, 0, 1'b0));
        rows.push_back(dir_row(pack_key(26, 27, 28, 29, 30, 31, 3, 5, 7), 1'b1, 0, 25, 13,
                               1'b0, 0, 0, 0, 1'b0));
        rows.push_back(dir_row(pack_key(26, 27, 28, 29, 30, 31, 3, 5, 7), 1'b0, 31, 16, 8,
                               1'b0, 0, 0, 0, 1'b0));

        calm <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].key != shadow_key || rows[r].decrypt != shadow_decrypt)
                retune(rows[r].key, rows[r].decrypt);
            send_block(rows[r].text, rows[r].typed, rows[r].want);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if ($urandom_range(0, 3) == 0)
                key = KEY_W'({$urandom, $urandom});
            else
                key = pack_key($urandom_range(0, 25), $urandom_range(0, 25),
                               $urandom_range(0, 25), $urandom_range(0, 25),
                               $urandom_range(0, 25), $urandom_range(0, 25),
                               $urandom_range(0, 25), $urandom_range(0, 25),
                               $urandom_range(0, 25));
            if ($urandom_range(0, 4) == 0) key = shadow_key;
            decrypt = 1'($urandom_range(0, 1));
            // no idling in the closing phases, and now and then elsewhere
            calm <= (ph >= RANDOM_PHASES - 4) || ($urandom_range(0, 3) == 0);
            retune(key, decrypt);
            repeat (PHASE_BLOCKS) begin
                for (int i = 0; i < 3; i++) begin
                    if ($urandom_range(0, 7) == 0)
                        text[i] = t_letter'($urandom_range(0, 31));
                    else
                        text[i] = t_letter'($urandom_range(0, 25));
                end
                send_block(text, 1'b0, '0);
            end
        end

        i_valid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d cipher blocks over %0d key/mode settings,",
                 blocks_sent, settings_used);
        $display("%0d singular-key decrypts, field mismatches: %0d",
                 singular_seen, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
